[rtl/hps_pkg.sv]
// Package for the heater PID supervisor: codes, limits and reset values.
package hps_pkg;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_HEATING   = 2'd1,
    MODE_REGULATED = 2'd2,
    MODE_SHUTDOWN  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ON       = 2'd1,
    OP_OFF      = 2'd2,
    OP_SHUTDOWN = 2'd3
  } op_t;

  localparam logic [2:0] FAULT_NONE       = 3'd0;
  localparam logic [2:0] FAULT_OVERHEAT   = 3'd1;
  localparam logic [2:0] FAULT_SENSOR     = 3'd2;
  localparam logic [2:0] FAULT_AMBIENT    = 3'd3;
  localparam logic [2:0] FAULT_REGULATION = 3'd4;

  localparam logic [2:0] CFG_GAIN_P       = 3'd0;
  localparam logic [2:0] CFG_GAIN_I       = 3'd1;
  localparam logic [2:0] CFG_GAIN_D       = 3'd2;
  localparam logic [2:0] CFG_OVERHEAT     = 3'd3;
  localparam logic [2:0] CFG_AMBIENT      = 3'd4;
  localparam logic [2:0] CFG_BAND         = 3'd5;
  localparam logic [2:0] CFG_AMBIENT_TO   = 3'd6;
  localparam logic [2:0] CFG_REGULATE_TO  = 3'd7;

  localparam logic [15:0] RST_GAIN_P      = 16'd256;
  localparam logic [15:0] RST_GAIN_I      = 16'd16;
  localparam logic [15:0] RST_GAIN_D      = 16'd0;
  localparam logic [15:0] RST_OVERHEAT    = 16'd19200;
  localparam logic [15:0] RST_AMBIENT     = 16'd2560;
  localparam logic [14:0] RST_BAND        = 15'd192;
  localparam logic [15:0] RST_AMBIENT_TO  = 16'd600;
  localparam logic [15:0] RST_REGULATE_TO = 16'd3000;

  localparam logic [4:0]         HYST_LIMIT     = 5'd10;
  localparam logic [4:0]         BAD_LIMIT      = 5'd5;
  localparam logic [4:0]         BAD_SAT        = 5'd31;
  localparam logic [9:0]         DUTY_MAX       = 10'd1023;
  localparam logic [16:0]        ERROR_EPSILON  = 17'd1;
  localparam logic signed [15:0] COLD_LIMIT     = -16'sd17482;
  localparam logic signed [31:0] START_INTEGRAL = 32'sd0;
  localparam logic [1:0]         BLINK_DIV      = 2'd3;
  localparam logic [15:0]        TIMER_SAT      = 16'hFFFF;

endpackage

[rtl/heater_pid_supervisor.sv]
// Heater supervisor top level: command decode, PID with anti-windup, timeouts, LED.
//
//  channel | ports                       | payload (low bit up)
//  --------+-----------------------------+-----------------------------------------------
//  in      | in_tvalid/in_tready         | tuser: opcode; tdata: sample, target, stop_reason
//  out     | out_tvalid/out_tready       | tdata: duty, pwm_enable, heater_mode, fault, led
//  cfg     | cfg_we/cfg_index/cfg_wdata  | one register per write, no read-back
//
// One item per cycle while out_tready holds; each passes the input then the result register.
// The PID step (three parallel multiplies, sum, clamp) sits between the input register
// and the result register, and all loop state updates when the item leaves that stage.
// rst_n is synchronous: it clears control state and loads the register reset values.
// A stalled result holds the stage behind it; the input stalls only when both are full.
module heater_pid_supervisor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  input  logic [39:0] in_tdata,   // sample[15:0], target[31:16], stop_reason[34:32], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // duty[9:0], pwm_enable[10], heater_mode[12:11],
                                  // fault[15:13], led[16], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hps_pkg::*;

  // config registers
  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [15:0] overheat_r, ambient_r;
  logic [14:0] band_r;
  logic [15:0] ambient_to_r, regulate_to_r;

  // loop state
  mode_t              mode_r, mode_nxt;
  logic [2:0]         fault_r, fault_nxt;
  logic signed [15:0] setpoint_r, setpoint_nxt;
  logic [4:0]         bad_r, bad_nxt;
  logic [15:0]        timer_r, timer_nxt;
  logic [4:0]         hyst_r, hyst_nxt;
  logic [1:0]         blink_r, blink_nxt;
  logic               led_r, led_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [16:0] last_err_r, last_err_nxt;
  logic [9:0]         last_duty_r, last_duty_nxt;

  // input stage
  logic               s1_v_r;
  op_t                s1_op_r;
  logic signed [15:0] s1_sample_r, s1_target_r;
  logic [2:0]         s1_reason_r;

  logic        out_v_r;
  logic [23:0] out_data_r;

  logic in_fire, s1_go;

  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // datapath
  logic signed [16:0] err, deriv_lo;
  logic [16:0]        mag;
  logic signed [32:0] acc;
  logic signed [31:0] integ_upd;
  logic signed [31:0] integ_pid;
  logic signed [16:0] gp_s, gi_s, gd_s;
  logic signed [17:0] deriv;
  logic signed [33:0] prod_p;
  logic signed [48:0] prod_i;
  logic signed [34:0] prod_d;
  logic signed [50:0] pid_sum;
  logic [42:0]        duty_raw;
  logic [9:0]         duty_new;
  logic [15:0]        timer_inc;
  logic               overheat, cold, in_band;
  logic               active_nxt;

  assign err  = 17'(setpoint_r) - 17'(s1_sample_r);
  assign mag  = err[16] ? 17'(-err) : 17'(err);
  assign acc  = 33'(integ_r) + 33'(err);
  assign integ_upd = (acc[32] != acc[31]) ? (acc[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                          : acc[31:0];
  // integrate only while |error| exceeds ERROR_EPSILON and duty is not pinned at full
  assign integ_pid = ((mag > ERROR_EPSILON) && (last_duty_r < DUTY_MAX)) ? integ_upd
                                                                          : integ_r;
  assign deriv_lo = last_err_r;
  assign deriv = 18'(err) - 18'(deriv_lo);
  assign gp_s = {1'b0, gain_p_r};
  assign gi_s = {1'b0, gain_i_r};
  assign gd_s = {1'b0, gain_d_r};
  assign prod_p = gp_s * err;
  assign prod_i = gi_s * integ_pid;
  assign prod_d = gd_s * deriv;
  assign pid_sum = 51'(prod_p) + 51'(prod_i) + 51'(prod_d);
  assign duty_raw = pid_sum[50:8];
  assign timer_inc = (timer_r == TIMER_SAT) ? timer_r : timer_r + 16'd1;
  assign overheat = s1_sample_r > $signed(overheat_r);
  assign cold     = s1_sample_r < COLD_LIMIT;
  assign in_band  = mag <= {2'b00, band_r};

  always_comb begin
    if (pid_sum[50]) begin
      duty_new = 10'd0;
    end else if ((|duty_raw[42:10]) || (duty_raw[9:0] > DUTY_MAX)) begin
      duty_new = DUTY_MAX;
    end else begin
      duty_new = duty_raw[9:0];
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    fault_nxt     = fault_r;
    setpoint_nxt  = setpoint_r;
    bad_nxt       = bad_r;
    timer_nxt     = timer_r;
    hyst_nxt      = hyst_r;
    blink_nxt     = blink_r;
    led_nxt       = led_r;
    integ_nxt     = integ_r;
    last_err_nxt  = last_err_r;
    last_duty_nxt = last_duty_r;
    case (s1_op_r)
      OP_TICK: begin
        if (mode_r == MODE_HEATING || mode_r == MODE_REGULATED) begin
          if (overheat) begin
            mode_nxt  = MODE_SHUTDOWN;
            fault_nxt = FAULT_OVERHEAT;
            led_nxt   = 1'b0;
          end else if (cold) begin
            if (bad_r != BAD_SAT) begin
              bad_nxt = bad_r + 5'd1;
            end
            if (bad_nxt > BAD_LIMIT) begin
              mode_nxt  = MODE_SHUTDOWN;
              fault_nxt = FAULT_SENSOR;
              led_nxt   = 1'b0;
            end
          end else begin
            bad_nxt       = 5'd0;
            integ_nxt     = integ_pid;
            last_err_nxt  = err;
            last_duty_nxt = duty_new;
            if (mode_r == MODE_HEATING) begin
              timer_nxt = timer_inc;
            end
            if ((mode_r == MODE_HEATING) && (s1_sample_r < $signed(ambient_r)) &&
                (timer_inc > ambient_to_r)) begin
              mode_nxt  = MODE_SHUTDOWN;
              fault_nxt = FAULT_AMBIENT;
              led_nxt   = 1'b0;
            end else if ((mode_r == MODE_HEATING) && (s1_sample_r < setpoint_r) &&
                         (timer_inc > regulate_to_r)) begin
              mode_nxt  = MODE_SHUTDOWN;
              fault_nxt = FAULT_REGULATION;
              led_nxt   = 1'b0;
            end else begin
              if (in_band) begin
                if (hyst_r >= HYST_LIMIT) begin
                  hyst_nxt = HYST_LIMIT;
                  mode_nxt = MODE_REGULATED;
                end else begin
                  hyst_nxt = hyst_r + 5'd1;
                end
              end else begin
                if (hyst_r <= 5'd1) begin
                  hyst_nxt  = 5'd0;
                  timer_nxt = 16'd0;
                  mode_nxt  = MODE_HEATING;
                end else begin
                  hyst_nxt = hyst_r - 5'd1;
                end
              end
              if (mode_nxt == MODE_REGULATED) begin
                led_nxt = 1'b1;
              end else if (blink_r >= BLINK_DIV) begin
                blink_nxt = 2'd0;
                led_nxt   = !led_r;
              end else begin
                blink_nxt = blink_r + 2'd1;
              end
            end
          end
        end
      end
      OP_ON: begin
        if (mode_r != MODE_HEATING && mode_r != MODE_REGULATED) begin
          last_duty_nxt = 10'd0;
          integ_nxt     = START_INTEGRAL;
          last_err_nxt  = 17'sd0;
          setpoint_nxt  = s1_target_r;
          hyst_nxt      = 5'd0;
          bad_nxt       = 5'd0;
          timer_nxt     = 16'd0;
          mode_nxt      = MODE_HEATING;
          led_nxt       = 1'b0;
        end
      end
      OP_OFF: begin
        mode_nxt  = MODE_OFF;
        fault_nxt = s1_reason_r;
        led_nxt   = 1'b0;
      end
      default: begin
        mode_nxt  = MODE_SHUTDOWN;
        fault_nxt = s1_reason_r;
        led_nxt   = 1'b0;
      end
    endcase
  end

  assign active_nxt = (mode_nxt == MODE_HEATING) || (mode_nxt == MODE_REGULATED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= RST_GAIN_P;
      gain_i_r      <= RST_GAIN_I;
      gain_d_r      <= RST_GAIN_D;
      overheat_r    <= RST_OVERHEAT;
      ambient_r     <= RST_AMBIENT;
      band_r        <= RST_BAND;
      ambient_to_r  <= RST_AMBIENT_TO;
      regulate_to_r <= RST_REGULATE_TO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P:      gain_p_r      <= cfg_wdata;
        CFG_GAIN_I:      gain_i_r      <= cfg_wdata;
        CFG_GAIN_D:      gain_d_r      <= cfg_wdata;
        CFG_OVERHEAT:    overheat_r    <= cfg_wdata;
        CFG_AMBIENT:     ambient_r     <= cfg_wdata;
        CFG_BAND:        band_r        <= cfg_wdata[14:0];
        CFG_AMBIENT_TO:  ambient_to_r  <= cfg_wdata;
        CFG_REGULATE_TO: regulate_to_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      fault_r     <= FAULT_NONE;
      setpoint_r  <= 16'sd0;
      bad_r       <= 5'd0;
      timer_r     <= 16'd0;
      hyst_r      <= 5'd0;
      blink_r     <= 2'd0;
      led_r       <= 1'b0;
      integ_r     <= 32'sd0;
      last_err_r  <= 17'sd0;
      last_duty_r <= 10'd0;
    end else if (s1_go) begin
      mode_r      <= mode_nxt;
      fault_r     <= fault_nxt;
      setpoint_r  <= setpoint_nxt;
      bad_r       <= bad_nxt;
      timer_r     <= timer_nxt;
      hyst_r      <= hyst_nxt;
      blink_r     <= blink_nxt;
      led_r       <= led_nxt;
      integ_r     <= integ_nxt;
      last_err_r  <= last_err_nxt;
      last_duty_r <= last_duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_fire || (s1_v_r && !s1_go);
      out_v_r <= s1_go || (out_v_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= op_t'(in_tuser);
      s1_sample_r <= in_tdata[15:0];
      s1_target_r <= in_tdata[31:16];
      s1_reason_r <= in_tdata[34:32];
    end
    if (s1_go) begin
      out_data_r <= {7'd0, led_nxt, fault_nxt, mode_nxt, active_nxt,
                     active_nxt ? last_duty_nxt : 10'd0};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/hps_checker.sv]
// Port-level checker for the heater PID supervisor, bound to the top level.
module hps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import hps_pkg::*;

  logic [1:0] mode_w;
  assign mode_w = out_tdata[12:11];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without an accepted item two cycles earlier");

  a_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while result side is free");

  a_pwm_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10] == ((mode_w == MODE_HEATING) || (mode_w == MODE_REGULATED)))
                   && (out_tdata[10] || (out_tdata[9:0] == 10'd0)))
    else $error("pwm enable or duty inconsistent with mode");

endmodule

bind heater_pid_supervisor hps_checker u_hps_checker (.*);
